// ===== src/imm_pkg.sv =====
package imm_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF   = 8;
   localparam int ELEM_BITS_DEF = 16;

   // Fixed widths of the register and result fields
   localparam int CFG_BITS       = 4;
   localparam int OUT_BITS       = 35;
   localparam int RSP_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

   // Register indexes on the csr channel
   typedef enum logic [1:0] {
      REG_ROWS_OF_A,
      REG_INNER_SIZE,
      REG_COLS_OF_B,
      REG_UNUSED
   } reg_index_type;

   // Control that rides along the cell chain with each A element
   typedef struct packed {
      logic valid;
      logic first;   // t == 0: restart the sum
      logic last;    // t == n-1: sum complete after this product
   } link_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FEED,
      ST_DRAIN,
      ST_EMIT
   } imm_state_type;

   function automatic int idx_bits(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // 0 counts as 1, anything above max_dim as max_dim
   function automatic logic [CFG_BITS-1:0] clamp_dim(logic [CFG_BITS-1:0] v, int max_dim);
      logic [CFG_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_BITS'(1);
      end else if (int'(v) > max_dim) begin
         r = CFG_BITS'(max_dim);
      end
      return r;
   endfunction

endpackage

// ===== src/imm_cell.sv =====
module imm_cell #(
   parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF,
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
   localparam int IDX_BITS = imm_pkg::idx_bits(MAX_DIM)
) (
   input  logic                               clock,
   input  logic                               reset,
   // A element coming down the chain
   input  imm_pkg::link_ctl_type              ctl_i,
   input  logic signed [ELEM_BITS-1:0]        a_i,
   input  logic [IDX_BITS-1:0]                t_i,
   output imm_pkg::link_ctl_type              ctl_o,
   output logic signed [ELEM_BITS-1:0]        a_o,
   output logic [IDX_BITS-1:0]                t_o,
   // load of this cell's column of B
   input  logic                               b_wr_en,
   input  logic [IDX_BITS-1:0]                b_wr_row,
   input  logic signed [ELEM_BITS-1:0]        b_wr_data,
   // result chain, shifts toward cell 0
   input  logic                               shift,
   input  logic [imm_pkg::OUT_BITS-1:0]       res_i,
   output logic [imm_pkg::OUT_BITS-1:0]       res_o
);
   import imm_pkg::*;

   localparam int PROD_BITS = 2 * ELEM_BITS;

   link_ctl_type                ctl_ff, pctl_ff;
   logic signed [ELEM_BITS-1:0] a_ff;
   logic [IDX_BITS-1:0]         t_ff;
   logic signed [ELEM_BITS-1:0] b_col_ff [MAX_DIM];
   logic signed [ELEM_BITS-1:0] b_sel;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [63:0]          prod_wide;
   logic [OUT_BITS-1:0]         acc_ff, acc_in;
   logic [OUT_BITS-1:0]         res_ff, res_in;

   assign b_sel     = b_col_ff[t_i];
   assign prod_wide = 64'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (pctl_ff.valid) begin
         if (pctl_ff.first) begin
            acc_in = prod_wide[OUT_BITS-1:0];
         end else begin
            acc_in = acc_ff + prod_wide[OUT_BITS-1:0];
         end
      end
   end

   always_comb begin
      res_in = res_ff;
      if (pctl_ff.valid && pctl_ff.last) begin
         res_in = acc_in;
      end else if (shift) begin
         res_in = res_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         pctl_ff <= '0;
      end else begin
         ctl_ff  <= ctl_i;
         pctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_i;
      t_ff    <= t_i;
      prod_ff <= a_i * b_sel;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      if (b_wr_en) begin
         b_col_ff[b_wr_row] <= b_wr_data;
      end
   end

   assign ctl_o = ctl_ff;
   assign a_o   = a_ff;
   assign t_o   = t_ff;
   assign res_o = res_ff;

endmodule

// ===== src/integer_matrix_multiply.sv =====
// Channel  Dir  Ports                    Contents
// -------  ---  -----------------------  ----------------------------------------------
// req      in   req_tvalid/tready/tdata  tdata[ELEM_BITS-1:0] element (A row-major, then B)
// rsp      out  rsp_tvalid/tready/tdata  tdata[34:0] product_element; tlast last_element
// csr      in   csr_valid/ready          csr_index register, csr_data value (4 bits)
//
// Load: m*n + n*k items, one per cycle unless csr_valid. Column j of B goes into cell j.
// Compute, per row of C: stream the row of A into the cell chain (one read of the A
//   memory a cycle), let it pass the chain and the multiply/accumulate stages, then
//   shift the results out of cell 0.
// Reset is synchronous; all three dimensions come up as 1 and the load restarts.
//   Any register write restarts the load too. A and B stores have no reset.
// rsp stalls hold the result in cell 0; no new item is taken until C is delivered.
module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF,
   parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: element, from bit 0
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((ELEM_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // response: product_element, from bit 0
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [imm_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tlast,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [imm_pkg::CFG_BITS-1:0]           csr_data
);
   import imm_pkg::*;

   localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
   localparam int IDX_BITS  = idx_bits(MAX_DIM);
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS = idx_bits(DEPTH);
   localparam int CNT_BITS  = $clog2(2 * DEPTH + 1);

   imm_state_type state_ff, state_in;

   logic [CFG_BITS-1:0]  rows_ff, inner_ff, cols_ff;
   logic [DIM_BITS-1:0]  dim_m, dim_n, dim_k;
   logic [CNT_BITS-1:0]  size_a, total_m1;

   logic [CNT_BITS-1:0]  load_cnt_ff, load_cnt_in;
   logic [IDX_BITS-1:0]  b_col_ff, b_col_in, b_row_ff, b_row_in;
   logic [IDX_BITS-1:0]  t_ff, t_in, row_ff, row_in, col_ff, col_in;
   logic [ADDR_BITS-1:0] a_base_ff, a_base_in, rd_addr;

   logic signed [ELEM_BITS-1:0] store_a_ff [DEPTH];
   logic signed [ELEM_BITS-1:0] mem_q_ff;
   logic signed [ELEM_BITS-1:0] req_elem;

   link_ctl_type         inj_ctl_ff, inj_ctl_in;
   logic [IDX_BITS-1:0]  inj_t_ff;
   logic                 tail_d1_ff;

   logic csr_fire, req_fire, rsp_fire;
   logic is_a_item, a_wr, b_wr, rd_en, shift;
   logic t_done, row_done, col_done, load_done, tail_last;

   link_ctl_type                chain_ctl [MAX_DIM+1];
   logic signed [ELEM_BITS-1:0] chain_a   [MAX_DIM];
   logic [IDX_BITS-1:0]         chain_t   [MAX_DIM];
   logic [OUT_BITS-1:0]         res_w     [MAX_DIM+1];

   // effective sizes
   assign dim_m    = DIM_BITS'(clamp_dim(rows_ff, MAX_DIM));
   assign dim_n    = DIM_BITS'(clamp_dim(inner_ff, MAX_DIM));
   assign dim_k    = DIM_BITS'(clamp_dim(cols_ff, MAX_DIM));
   assign size_a   = CNT_BITS'(dim_m) * CNT_BITS'(dim_n);
   assign total_m1 = size_a + CNT_BITS'(dim_n) * CNT_BITS'(dim_k) - CNT_BITS'(1);

   assign req_elem  = req_tdata[ELEM_BITS-1:0];
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign is_a_item = load_cnt_ff < size_a;
   assign load_done = load_cnt_ff == total_m1;
   assign t_done    = DIM_BITS'(t_ff) == dim_n - DIM_BITS'(1);
   assign row_done  = DIM_BITS'(row_ff) == dim_m - DIM_BITS'(1);
   assign col_done  = DIM_BITS'(col_ff) == dim_k - DIM_BITS'(1);
   assign tail_last = chain_ctl[MAX_DIM].valid && chain_ctl[MAX_DIM].last;
   assign rd_addr   = a_base_ff + ADDR_BITS'(t_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && load_done) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (t_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tail_d1_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && col_done) begin
               state_in = row_done ? ST_LOAD : ST_FEED;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      csr_ready  = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rd_en      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            csr_ready  = 1'b1;
            req_tready = !csr_valid;
         end
         ST_FEED:  rd_en = 1'b1;
         ST_DRAIN: rd_en = 1'b0;
         ST_EMIT:  rsp_tvalid = 1'b1;
         default:  rd_en = 1'b0;
      endcase
   end

   assign a_wr  = req_fire && is_a_item;
   assign b_wr  = req_fire && !is_a_item;
   assign shift = rsp_fire;

   // counters
   always_comb begin
      load_cnt_in = load_cnt_ff;
      b_col_in    = b_col_ff;
      b_row_in    = b_row_ff;
      t_in        = t_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      a_base_in   = a_base_ff;
      if (csr_fire || (req_fire && load_done)) begin
         load_cnt_in = '0;
         b_col_in    = '0;
         b_row_in    = '0;
      end else if (req_fire) begin
         load_cnt_in = load_cnt_ff + CNT_BITS'(1);
         if (!is_a_item) begin
            if (DIM_BITS'(b_col_ff) == dim_k - DIM_BITS'(1)) begin
               b_col_in = '0;
               b_row_in = b_row_ff + IDX_BITS'(1);
            end else begin
               b_col_in = b_col_ff + IDX_BITS'(1);
            end
         end
      end
      if (rd_en) begin
         t_in = t_done ? '0 : t_ff + IDX_BITS'(1);
      end
      if (rsp_fire) begin
         if (col_done) begin
            col_in = '0;
            if (row_done) begin
               row_in    = '0;
               a_base_in = '0;
            end else begin
               row_in    = row_ff + IDX_BITS'(1);
               a_base_in = a_base_ff + ADDR_BITS'(dim_n);
            end
         end else begin
            col_in = col_ff + IDX_BITS'(1);
         end
      end
   end

   always_comb begin
      inj_ctl_in.valid = rd_en;
      inj_ctl_in.first = t_ff == '0;
      inj_ctl_in.last  = t_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         rows_ff     <= CFG_BITS'(1);
         inner_ff    <= CFG_BITS'(1);
         cols_ff     <= CFG_BITS'(1);
         load_cnt_ff <= '0;
         b_col_ff    <= '0;
         b_row_ff    <= '0;
         t_ff        <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         a_base_ff   <= '0;
         inj_ctl_ff  <= '0;
         tail_d1_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         b_col_ff    <= b_col_in;
         b_row_ff    <= b_row_in;
         t_ff        <= t_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         a_base_ff   <= a_base_in;
         inj_ctl_ff  <= inj_ctl_in;
         tail_d1_ff  <= tail_last;
         if (csr_fire) begin
            case (csr_index)
               REG_ROWS_OF_A:  rows_ff  <= csr_data;
               REG_INNER_SIZE: inner_ff <= csr_data;
               REG_COLS_OF_B:  cols_ff  <= csr_data;
               default:        rows_ff  <= rows_ff;   // unused index: restart only
            endcase
         end
      end
   end

   // A store: one write port for the load, one registered read port for the feed
   always_ff @(posedge clock) begin
      if (a_wr) begin
         store_a_ff[load_cnt_ff[ADDR_BITS-1:0]] <= req_elem;
      end
      if (rd_en) begin
         mem_q_ff <= store_a_ff[rd_addr];
      end
      inj_t_ff <= t_ff;
   end

   // head of the chain
   assign chain_ctl[0]     = inj_ctl_ff;
   assign chain_a[0]       = mem_q_ff;
   assign chain_t[0]       = inj_t_ff;
   assign res_w[MAX_DIM]   = '0;

   // one cell per column of C
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      if (j < MAX_DIM - 1) begin : g_mid
         imm_cell #(
            .ELEM_BITS (ELEM_BITS),
            .MAX_DIM   (MAX_DIM)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl_i     (chain_ctl[j]),
            .a_i       (chain_a[j]),
            .t_i       (chain_t[j]),
            .ctl_o     (chain_ctl[j+1]),
            .a_o       (chain_a[j+1]),
            .t_o       (chain_t[j+1]),
            .b_wr_en   (b_wr && (b_col_ff == IDX_BITS'(j))),
            .b_wr_row  (b_row_ff),
            .b_wr_data (req_elem),
            .shift     (shift),
            .res_i     (res_w[j+1]),
            .res_o     (res_w[j])
         );
      end else begin : g_tail
         imm_cell #(
            .ELEM_BITS (ELEM_BITS),
            .MAX_DIM   (MAX_DIM)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl_i     (chain_ctl[j]),
            .a_i       (chain_a[j]),
            .t_i       (chain_t[j]),
            .ctl_o     (chain_ctl[j+1]),
            .a_o       (),
            .t_o       (),
            .b_wr_en   (b_wr && (b_col_ff == IDX_BITS'(j))),
            .b_wr_row  (b_row_ff),
            .b_wr_data (req_elem),
            .shift     (shift),
            .res_i     (res_w[j+1]),
            .res_o     (res_w[j])
         );
      end
   end

   assign rsp_tdata = RSP_TDATA_BITS'(res_w[0]);
   assign rsp_tlast = row_done && col_done;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> state_ff == ST_LOAD && load_cnt_ff == '0)
      else $error("no return to load after last result");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> load_cnt_ff == '0 && b_col_ff == '0 && b_row_ff == '0)
      else $error("register write did not restart the load");

   a_inject_feed: assert property (@(posedge clock) disable iff (reset)
      inj_ctl_ff.valid |-> $past(state_ff) == ST_FEED)
      else $error("chain injection outside feed");
`endif

endmodule
